>>> design/pddm_pkg.sv
// Package for the PD differential-drive mixer: field widths, derived arithmetic widths,
// register indexes, reset values and the controller/datapath command and status types.
// Depends on nothing; every other design file depends on it.
package pddm_pkg;

    // Field widths fixed by the interface.
    localparam int DEV_W   = 16;
    localparam int TS_W    = 32;
    localparam int GAIN_W  = 10;
    localparam int BASE_W  = 10;
    localparam int MAX_W   = 8;
    localparam int PWM_W   = 8;

    // Configuration port.
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SPEED  = 3'd0,
        CFG_MAX_SPEED   = 3'd1,
        CFG_KP_Q8       = 3'd2,
        CFG_KD_Q8       = 3'd3,
        CFG_MIX_GAIN_Q8 = 3'd4
    } t_cfg_idx;

    localparam logic [BASE_W-1:0] BASE_SPEED_RST  = BASE_W'(150);
    localparam logic [MAX_W-1:0]  MAX_SPEED_RST   = MAX_W'(90);
    localparam logic [GAIN_W-1:0] KP_Q8_RST       = GAIN_W'(51);
    localparam logic [GAIN_W-1:0] KD_Q8_RST       = GAIN_W'(77);
    localparam logic [GAIN_W-1:0] MIX_GAIN_Q8_RST = GAIN_W'(166);

    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Derived arithmetic widths.
    localparam int DIFF_W  = DEV_W + 1;             // deviation change
    localparam int P_W     = DEV_W + GAIN_W;        // deviation * kp
    localparam int KDD_W   = GAIN_W + DIFF_W;       // kd * change
    localparam int NUM_W   = P_W + TS_W + 1;        // full signed numerator
    localparam int MAG_W   = NUM_W - 1;             // numerator magnitude, quotient bits
    localparam int CNT_W   = $clog2(MAG_W);
    localparam int CORR_W  = P_W + 2;               // signed correction
    localparam int MIXED_W = CORR_W + GAIN_W;       // correction * mixing gain
    localparam int SUM_W   = MIXED_W + 1;           // scaled wheel speed

    typedef struct packed {
        logic load_in;
        logic prod;
        logic scale;
        logic sum;
        logic div_load;
        logic div_step;
        logic sign;
        logic mix;
        logic wheel;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage

>>> design/pddm_in_if.sv
// Input channel of the PD mixer: valid/ready handshake with deviation and timestamp.
// Depends on pddm_pkg for the field widths.
interface pddm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pddm_pkg::DEV_W-1:0]  deviation;
    logic        [pddm_pkg::TS_W-1:0]   timestamp_us;

    modport source (output valid, output deviation, output timestamp_us, input ready);
    modport sink   (input valid, input deviation, input timestamp_us, output ready);
endinterface

>>> design/pddm_out_if.sv
// Output channel of the PD mixer: valid/ready handshake with both wheel commands.
// Depends on pddm_pkg for the field widths.
interface pddm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          left_forward;
    logic [pddm_pkg::PWM_W-1:0]    left_pwm;
    logic                          right_forward;
    logic [pddm_pkg::PWM_W-1:0]    right_pwm;

    modport source (output valid, output left_forward, output left_pwm,
                    output right_forward, output right_pwm, input ready);
    modport sink   (input valid, input left_forward, input left_pwm,
                    input right_forward, input right_pwm, output ready);
endinterface

>>> design/pddm_ctrl.sv
// Sequencing state machine of the PD mixer: steps the datapath through each item.
// Depends on pddm_pkg for the command and status structs.
module pddm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output pddm_pkg::t_dp_cmd    o_cmd,
    input  pddm_pkg::t_dp_status i_status
);
    import pddm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_SCALE,
        S_SUM,
        S_LOAD,
        S_DIVIDE,
        S_SIGN,
        S_MIX,
        S_WHEEL,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prod     = (r_state == S_PROD);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.div_load = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.sign     = (r_state == S_SIGN);
        o_cmd.mix      = (r_state == S_MIX);
        o_cmd.wheel    = (r_state == S_WHEEL);
        o_cmd.load_out = (r_state == S_OUT) && w_slot_free;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:   n_state = S_SCALE;
            S_SCALE:  n_state = S_SUM;
            S_SUM:    n_state = S_LOAD;
            S_LOAD:   n_state = S_DIVIDE;
            S_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN:   n_state = S_MIX;
            S_MIX:    n_state = S_WHEEL;
            S_WHEEL:  n_state = S_OUT;
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // A new result may only be loaded once the previous one has been taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/pddm_datapath.sv
// Datapath of the PD mixer: sample history, gain products, restoring divider,
// mixing and wheel clamp, each step enabled by a controller command.
// Depends on pddm_pkg for widths and the command and status structs.
module pddm_datapath #(
    parameter int GAIN_FRAC_BITS = pddm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pddm_pkg::t_dp_cmd                  i_cmd,
    output pddm_pkg::t_dp_status               o_status,
    input  logic signed [pddm_pkg::DEV_W-1:0]  i_deviation,
    input  logic        [pddm_pkg::TS_W-1:0]   i_timestamp_us,
    input  logic        [pddm_pkg::BASE_W-1:0] i_base_speed,
    input  logic        [pddm_pkg::MAX_W-1:0]  i_max_speed,
    input  logic        [pddm_pkg::GAIN_W-1:0] i_kp_q8,
    input  logic        [pddm_pkg::GAIN_W-1:0] i_kd_q8,
    input  logic        [pddm_pkg::GAIN_W-1:0] i_mix_gain_q8,
    output logic                               o_left_forward,
    output logic        [pddm_pkg::PWM_W-1:0]  o_left_pwm,
    output logic                               o_right_forward,
    output logic        [pddm_pkg::PWM_W-1:0]  o_right_pwm
);
    import pddm_pkg::*;

    localparam int FRAC  = GAIN_FRAC_BITS;
    localparam int DIV_W = TS_W + FRAC;     // divisor is elapsed * 2^FRAC

    typedef struct packed {
        logic             fwd;
        logic [PWM_W-1:0] pwm;
    } t_wheel;

    // Sample history.
    logic signed [DEV_W-1:0]   r_prev_error;
    logic        [TS_W-1:0]    r_prev_time;

    // Pipeline of the computation.
    logic signed [DEV_W-1:0]   r_dev;
    logic signed [DIFF_W-1:0]  r_diff;
    logic        [TS_W-1:0]    r_e;
    logic                      r_kd_en;
    logic signed [P_W-1:0]     r_pk;
    logic signed [KDD_W-1:0]   r_kdd;
    logic signed [NUM_W-1:0]   r_pke;
    logic signed [NUM_W-1:0]   r_num;
    logic                      r_neg;
    logic        [MAG_W-1:0]   r_quo;
    logic        [DIV_W:0]     r_rem;
    logic        [DIV_W-1:0]   r_den;
    logic        [CNT_W-1:0]   r_cnt;
    logic signed [CORR_W-1:0]  r_corr;
    logic signed [MIXED_W-1:0] r_mixed;
    logic signed [SUM_W-1:0]   r_xl;
    logic signed [SUM_W-1:0]   r_xr;
    logic                      r_left_fwd;
    logic        [PWM_W-1:0]   r_left_pwm;
    logic                      r_right_fwd;
    logic        [PWM_W-1:0]   r_right_pwm;

    logic        [TS_W-1:0]    w_elapsed;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [P_W-1:0]     w_dev_x;
    logic signed [P_W-1:0]     w_kp_x;
    logic signed [KDD_W-1:0]   w_kd_x;
    logic signed [KDD_W-1:0]   w_diff_x;
    logic signed [NUM_W-1:0]   w_pk_x;
    logic signed [NUM_W-1:0]   w_e_x;
    logic signed [NUM_W-1:0]   w_num_abs;
    logic        [DIV_W:0]     w_rem_sh;
    logic                      w_qbit;
    logic signed [CORR_W-1:0]  w_q;
    logic signed [MIXED_W-1:0] w_corr_x;
    logic signed [MIXED_W-1:0] w_mix_x;
    logic signed [SUM_W-1:0]   w_base_x;
    logic signed [SUM_W-1:0]   w_mixed_x;
    t_wheel                    w_left;
    t_wheel                    w_right;

    // Truncation toward zero of x / 2^FRAC is the magnitude shifted right; a result
    // of zero counts as forward.
    function automatic t_wheel wheel_calc(input logic signed [SUM_W-1:0] x,
                                          input logic [MAX_W-1:0] lim);
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] mag;
        t_wheel           w;
        a     = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
        mag   = a >> FRAC;
        w.fwd = !x[SUM_W-1] || (mag == '0);
        w.pwm = (mag > SUM_W'(lim)) ? lim : mag[PWM_W-1:0];
        return w;
    endfunction

    assign w_elapsed = i_timestamp_us - r_prev_time;
    assign w_diff    = DIFF_W'(i_deviation) - DIFF_W'(r_prev_error);

    assign w_dev_x   = P_W'(r_dev);
    assign w_kp_x    = P_W'($signed({1'b0, i_kp_q8}));
    assign w_kd_x    = KDD_W'($signed({1'b0, i_kd_q8}));
    assign w_diff_x  = KDD_W'(r_diff);
    assign w_pk_x    = NUM_W'(r_pk);
    assign w_e_x     = NUM_W'($signed({1'b0, r_e}));
    assign w_num_abs = r_num[NUM_W-1] ? -r_num : r_num;

    // One restoring division step per cycle, quotient bits shift in behind the dividend.
    assign w_rem_sh  = {r_rem[DIV_W-1:0], r_quo[MAG_W-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_den});

    assign w_q       = $signed({1'b0, r_quo[CORR_W-2:0]});
    assign w_corr_x  = MIXED_W'(r_corr);
    assign w_mix_x   = MIXED_W'($signed({1'b0, i_mix_gain_q8}));
    assign w_base_x  = SUM_W'($signed({1'b0, i_base_speed, {FRAC{1'b0}}}));
    assign w_mixed_x = SUM_W'(r_mixed);

    assign w_left    = wheel_calc(r_xl, i_max_speed);
    assign w_right   = wheel_calc(r_xr, i_max_speed);

    assign o_status.div_last = (r_cnt == CNT_W'(MAG_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
            r_prev_time  <= TS_W'(1);
        end else if (i_cmd.load_in) begin
            r_prev_error <= i_deviation;
            r_prev_time  <= i_timestamp_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dev   <= i_deviation;
            r_diff  <= w_diff;
            // With no time elapsed the derivative drops out and the divisor is 2^FRAC.
            r_e     <= (w_elapsed == '0) ? TS_W'(1) : w_elapsed;
            r_kd_en <= (w_elapsed != '0);
        end
        if (i_cmd.prod) begin
            r_pk  <= w_dev_x * w_kp_x;
            r_kdd <= r_kd_en ? (w_kd_x * w_diff_x) : '0;
        end
        if (i_cmd.scale) begin
            r_pke <= w_pk_x * w_e_x;
        end
        if (i_cmd.sum) begin
            r_num <= r_pke + NUM_W'(r_kdd);
        end
        if (i_cmd.div_load) begin
            r_neg <= r_num[NUM_W-1];
            r_quo <= w_num_abs[MAG_W-1:0];
            r_rem <= '0;
            r_den <= {r_e, {FRAC{1'b0}}};
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
            r_quo <= {r_quo[MAG_W-2:0], w_qbit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.sign) begin
            r_corr <= r_neg ? -w_q : w_q;
        end
        if (i_cmd.mix) begin
            r_mixed <= w_corr_x * w_mix_x;
        end
        if (i_cmd.wheel) begin
            r_xl <= w_base_x - w_mixed_x;
            r_xr <= w_base_x + w_mixed_x;
        end
        if (i_cmd.load_out) begin
            r_left_fwd  <= w_left.fwd;
            r_left_pwm  <= w_left.pwm;
            r_right_fwd <= w_right.fwd;
            r_right_pwm <= w_right.pwm;
        end
    end

    assign o_left_forward  = r_left_fwd;
    assign o_left_pwm      = r_left_pwm;
    assign o_right_forward = r_right_fwd;
    assign o_right_pwm     = r_right_pwm;

endmodule

>>> design/pd_differential_drive_mixer_core.sv
// PD differential-drive mixer, top level: configuration registers, controller and datapath.
// The block takes one item at a time and accepts the next only once the result is in the
// output register; the 58-step restoring divider forms the correction quotient.
// Reset (synchronous, active low) restores register defaults, clears the sample history
// to deviation 0 at time 1 and empties the output register; no clearing pass is needed.
module pd_differential_drive_mixer_core #(
    parameter int GAIN_FRAC_BITS = pddm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pddm_in_if.sink                              i_in,
    pddm_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [pddm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pddm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pddm_pkg::*;

    // Configuration registers. The host must write them only while the block is idle;
    // the block itself does not enforce this. The datapath reads them directly with no
    // shadow copy. Writes to an index past the last register are dropped.
    logic [BASE_W-1:0] r_base_speed;
    logic [MAX_W-1:0]  r_max_speed;
    logic [GAIN_W-1:0] r_kp_q8;
    logic [GAIN_W-1:0] r_kd_q8;
    logic [GAIN_W-1:0] r_mix_gain_q8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed  <= BASE_SPEED_RST;
            r_max_speed   <= MAX_SPEED_RST;
            r_kp_q8       <= KP_Q8_RST;
            r_kd_q8       <= KD_Q8_RST;
            r_mix_gain_q8 <= MIX_GAIN_Q8_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_SPEED:  r_base_speed  <= i_cfg_data[BASE_W-1:0];
                CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data[MAX_W-1:0];
                CFG_KP_Q8:       r_kp_q8       <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_Q8:       r_kd_q8       <= i_cfg_data[GAIN_W-1:0];
                CFG_MIX_GAIN_Q8: r_mix_gain_q8 <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The controller walks each item through the datapath: capture and history
    // update, the two gain products, scaling by elapsed time, the numerator sum, the
    // divider load, one quotient bit per cycle, sign restore, mixing, the two wheel
    // sums, and finally the clamp into the output register. The output register
    // lets a finished result wait for the sink while the next input is already taken.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pddm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    pddm_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_deviation     (i_in.deviation),
        .i_timestamp_us  (i_in.timestamp_us),
        .i_base_speed    (r_base_speed),
        .i_max_speed     (r_max_speed),
        .i_kp_q8         (r_kp_q8),
        .i_kd_q8         (r_kd_q8),
        .i_mix_gain_q8   (r_mix_gain_q8),
        .o_left_forward  (o_out.left_forward),
        .o_left_pwm      (o_out.left_pwm),
        .o_right_forward (o_out.right_forward),
        .o_right_pwm     (o_out.right_pwm)
    );

    // Once an item is taken, the block is busy and refuses the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is still being computed");

    // A result never overwrites one that the sink has not taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("output register loaded over a pending result");

    // The divider runs exactly one step per quotient bit before the sign is restored.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_load |-> ##(MAG_W + 1) w_cmd.sign)
        else $error("divider did not finish in the expected number of steps");

endmodule

>>> tb/pddm_mixer_checker.sv
`timescale 1ns / 1ps
// Checker for the PD differential-drive mixer: watches both channels and the register port,
// predicts each wheel command and compares it field by field. Depends on pddm_pkg and the
// pddm_in_if / pddm_out_if interfaces.
module pddm_mixer_checker #(
    parameter int GAIN_FRAC_BITS = pddm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pddm_in_if                              i_in_mon,
    pddm_out_if                             i_out_mon,
    input  logic                            i_cfg_we,
    input  logic [pddm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pddm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import pddm_pkg::*;

    localparam logic [TS_W-1:0] HIST_TS_RST = TS_W'(1);

    typedef struct packed {
        logic             left_forward;
        logic [PWM_W-1:0] left_pwm;
        logic             right_forward;
        logic [PWM_W-1:0] right_pwm;
    } t_wheel_cmd;

    // Shadow copy of the gain registers and of the sample history.
    logic [BASE_W-1:0]        base_speed;
    logic [MAX_W-1:0]         max_speed;
    logic [GAIN_W-1:0]        kp_gain;
    logic [GAIN_W-1:0]        kd_gain;
    logic [GAIN_W-1:0]        mix_gain;
    logic signed [DEV_W-1:0]  last_error;
    logic [TS_W-1:0]          last_stamp;

    t_wheel_cmd pending_cmds[$];
    int         fault_tally;
    int         cmd_tally;

    // Split a signed wheel speed into direction and clamped magnitude; zero counts as forward.
    function automatic logic [PWM_W:0] drive_wheel(input longint speed);
        longint mag;
        mag = (speed < 0) ? -speed : speed;
        if (mag > longint'(max_speed))
            mag = longint'(max_speed);
        return {speed >= 0, PWM_W'(mag)};
    endfunction

    function automatic t_wheel_cmd mix_command(input logic signed [DEV_W-1:0] dev,
                                               input logic [TS_W-1:0] stamp);
        longint     scale;
        longint     dev_l;
        longint     change;
        longint     span;
        longint     corr;
        longint     mixed;
        longint     base_s;
        logic [TS_W-1:0] elapsed;
        t_wheel_cmd cmd;
        scale   = longint'(1) << GAIN_FRAC_BITS;
        dev_l   = longint'(dev);
        change  = dev_l - longint'(last_error);
        elapsed = stamp - last_stamp;
        span    = longint'(elapsed);
        // With no time between samples the derivative term drops out.
        if (span == 0)
            corr = (dev_l * longint'(kp_gain)) / scale;
        else
            corr = (dev_l * longint'(kp_gain) * span + longint'(kd_gain) * change)
                   / (scale * span);
        mixed  = corr * longint'(mix_gain);
        base_s = longint'(base_speed) * scale;
        {cmd.left_forward, cmd.left_pwm}   = drive_wheel((base_s - mixed) / scale);
        {cmd.right_forward, cmd.right_pwm} = drive_wheel((base_s + mixed) / scale);
        return cmd;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_wheel_cmd got;
        t_wheel_cmd want;
        if (!i_rst_n) begin
            base_speed  <= BASE_SPEED_RST;
            max_speed   <= MAX_SPEED_RST;
            kp_gain     <= KP_Q8_RST;
            kd_gain     <= KD_Q8_RST;
            mix_gain    <= MIX_GAIN_Q8_RST;
            last_error  <= '0;
            last_stamp  <= HIST_TS_RST;
            pending_cmds.delete();
            fault_tally = 0;
            cmd_tally   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_SPEED:  base_speed <= i_cfg_data[BASE_W-1:0];
                    CFG_MAX_SPEED:   max_speed  <= i_cfg_data[MAX_W-1:0];
                    CFG_KP_Q8:       kp_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD_Q8:       kd_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIX_GAIN_Q8: mix_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.left_forward, i_out_mon.left_pwm,
                        i_out_mon.right_forward, i_out_mon.right_pwm};
                if (pending_cmds.size() == 0) begin
                    $error("wheel command transfer with no sample waiting");
                    fault_tally++;
                end else begin
                    want = pending_cmds.pop_front();
                    cmd_tally++;
                    if (got.left_forward !== want.left_forward) begin
                        $error("left_forward: expected %0d, actual %0d",
                               want.left_forward, got.left_forward);
                        fault_tally++;
                    end
                    if (got.left_pwm !== want.left_pwm) begin
                        $error("left_pwm: expected %0d, actual %0d",
                               want.left_pwm, got.left_pwm);
                        fault_tally++;
                    end
                    if (got.right_forward !== want.right_forward) begin
                        $error("right_forward: expected %0d, actual %0d",
                               want.right_forward, got.right_forward);
                        fault_tally++;
                    end
                    if (got.right_pwm !== want.right_pwm) begin
                        $error("right_pwm: expected %0d, actual %0d",
                               want.right_pwm, got.right_pwm);
                        fault_tally++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pending_cmds.push_back(mix_command(i_in_mon.deviation, i_in_mon.timestamp_us));
                last_error <= i_in_mon.deviation;
                last_stamp <= i_in_mon.timestamp_us;
            end
        end
        o_pending    <= pending_cmds.size();
        o_fail_count <= fault_tally;
        o_checked    <= cmd_tally;
    end

endmodule

>>> tb/pd_differential_drive_mixer_core_tb.sv
`timescale 1ns / 1ps
// Top of the PD mixer testbench: clock, reset, sample stimulus, register programming and the
// verdict. Depends on pddm_pkg, both channel interfaces, the core and pddm_mixer_checker.
module pd_differential_drive_mixer_core_tb;
    import pddm_pkg::*;

    localparam int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 38;
    localparam int SETTLE_CYCLES  = 8;
    // Closing wait after every result has been seen.
    localparam int TAIL_CYCLES    = 80;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 106;
    localparam int QUIET_PHASE    = 2;
    localparam int HOLD_PHASE     = 1;
    // A clean run needs well under a millisecond; the limit is several times that.
    localparam int STOP_AFTER_NS  = 5_000_000;

    localparam logic signed [DEV_W-1:0] DEV_MAX = {1'b0, {(DEV_W-1){1'b1}}};
    localparam logic signed [DEV_W-1:0] DEV_MIN = {1'b1, {(DEV_W-1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0]   REG_ALL_ONES = '1;
    localparam logic [CFG_DATA_W-1:0]   GAIN_UNITY   = CFG_DATA_W'(1 << GAIN_FRAC_BITS);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // When idle_en is low neither side inserts gaps or stalls.
    bit                      idle_en;
    int                      samples_sent;
    int                      settings_used;
    logic [TS_W-1:0]         last_ts;
    logic signed [DEV_W-1:0] last_dev;

    int fail_count;
    int pending;
    int checked;

    pddm_in_if  in_ch ();
    pddm_out_if out_ch ();

    pd_differential_drive_mixer_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pddm_mixer_checker #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random while idling is enabled, otherwise it is always ready.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // Safety net: a hang anywhere ends the run as a failure.
    initial begin
        #(STOP_AFTER_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one sample, possibly after some idle cycles, and hold it until the core takes it.
    // Valid is left high after the transfer so back-to-back samples need no dead cycle.
    task automatic send_sample(input logic signed [DEV_W-1:0] dev, input logic [TS_W-1:0] ts);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.deviation    <= dev;
        in_ch.timestamp_us <= ts;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        last_ts  = ts;
        last_dev = dev;
        samples_sent++;
    endtask

    // Stop offering samples and wait until every predicted wheel command has been seen.
    // The first edge lets the checker book a transfer that happened at the previous edge.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all five gain registers, then one index past the last register, which the core
    // must ignore. Write enable stays high across the burst and drops once at the end.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] base,
                                input logic [CFG_DATA_W-1:0] max_spd,
                                input logic [CFG_DATA_W-1:0] kp,
                                input logic [CFG_DATA_W-1:0] kd,
                                input logic [CFG_DATA_W-1:0] mix);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BASE_SPEED;
        cfg_data <= base;
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_SPEED;
        cfg_data <= max_spd;
        @(posedge i_clk);
        cfg_idx  <= CFG_KP_Q8;
        cfg_data <= kp;
        @(posedge i_clk);
        cfg_idx  <= CFG_KD_Q8;
        cfg_data <= kd;
        @(posedge i_clk);
        cfg_idx  <= CFG_MIX_GAIN_Q8;
        cfg_data <= mix;
        @(posedge i_clk);
        cfg_idx  <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_MIX_GAIN_Q8 + 1));
        cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // Register values for random phases lean on the extremes: zero, full scale, or anything.
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int unsigned hi);
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_DATA_W'(hi);
            default: return CFG_DATA_W'($urandom_range(hi));
        endcase
    endfunction

    initial begin
        logic [TS_W-1:0]         ts;
        logic signed [DEV_W-1:0] dev;

        in_ch.valid        <= 1'b0;
        in_ch.deviation    <= '0;
        in_ch.timestamp_us <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_BASE_SPEED;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        idle_en       = 1'b1;
        samples_sent  = 0;
        settings_used = 0;
        last_ts       = TS_W'(1);
        last_dev      = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples with the reset gains. The first one carries the same time stamp
        // as the cleared history, so the derivative term must drop out.
        send_sample('0, TS_W'(1));
        send_sample(DEV_MAX, TS_W'(2));
        send_sample(DEV_MIN, TS_W'(3));
        send_sample(DEV_MIN, TS_W'(3));
        // The time stamp wraps between the next two samples.
        send_sample(DEV_W'(1000), 32'hFFFF_FFF0);
        send_sample(-DEV_W'(1000), 32'h0000_0010);
        send_sample('0, 32'h0000_0011);
        // Going one microsecond back in time is the longest possible elapsed time.
        send_sample(-DEV_W'(1), 32'h0000_0010);

        // Every register at full scale; max_speed gets all ones and keeps its low byte.
        wait_for_results();
        program_regs(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES);
        send_sample(DEV_MAX, 32'h0000_0011);
        send_sample(DEV_MIN, 32'h0000_0012);
        send_sample(DEV_MIN, 32'h0000_0012);
        send_sample(DEV_MAX, 32'hFFFF_FFFF);
        send_sample(DEV_W'(1), 32'hFFFF_FFFF);

        // Every register at zero: both wheels sit at exactly zero speed, reported as forward.
        wait_for_results();
        program_regs('0, '0, '0, '0, '0);
        send_sample(DEV_MAX, TS_W'(5));
        send_sample(DEV_MIN, TS_W'(6));

        // Zero base speed and unity gains drive one wheel backward, then into the clamp.
        wait_for_results();
        program_regs('0, CFG_DATA_W'(2**MAX_W - 1), GAIN_UNITY, '0, GAIN_UNITY);
        send_sample(DEV_W'(100), TS_W'(7));
        send_sample(-DEV_W'(100), TS_W'(8));
        send_sample('0, TS_W'(9));
        send_sample(DEV_W'(1000), TS_W'(10));
        send_sample(-DEV_W'(1000), TS_W'(10));

        // Random phases, each with its own gain setting. Time steps are often short so the
        // derivative term matters, with repeats, long gaps and wraps mixed in.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            program_regs(pick_reg(2**BASE_W - 1), pick_reg(2**MAX_W - 1),
                         pick_reg(2**GAIN_W - 1), pick_reg(2**GAIN_W - 1),
                         pick_reg(2**GAIN_W - 1));
            idle_en = (p != QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once in the run the sender holds off until the core has fully drained.
                if (p == HOLD_PHASE && n == PHASE_ITEMS / 2)
                    wait_for_results();
                case ($urandom_range(9))
                    0, 1:    ts = last_ts;
                    2, 3, 4: ts = last_ts + TS_W'($urandom_range(8, 1));
                    5, 6, 7: ts = last_ts + TS_W'($urandom_range(50000, 9));
                    8:       ts = TS_W'($urandom);
                    default: ts = 32'hFFFF_FF00 + TS_W'($urandom_range(255));
                endcase
                case ($urandom_range(3))
                    0:       dev = DEV_W'($urandom_range(128)) - DEV_W'(64);
                    1:       dev = DEV_W'($urandom);
                    2:       dev = last_dev + DEV_W'($urandom_range(8)) - DEV_W'(4);
                    default: dev = $urandom_range(1) ? DEV_MAX : DEV_MIN;
                endcase
                send_sample(dev, ts);
            end
        end

        idle_en = 1'b1;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d line samples under %0d gain settings; %0d wheel commands compared.",
                 samples_sent, settings_used, checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
